// File: rtl/core/des_pkg.sv
package des_pkg;

  localparam int unsigned BLOCK_W    = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned SUBKEY_W   = 48;
  localparam int unsigned NUM_ROUNDS = 16;

  // Initial permutation: output bit k from the top takes input bit IP_TAB[k] from the top.
  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [5:0] E_TAB [48] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] P_TAB [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Total left rotation of the key halves after each round's shift has been applied.
  localparam int unsigned ROT_SUM [16] = '{
    1, 2, 4, 6, 8, 10, 12, 14, 15, 17, 19, 21, 23, 25, 27, 28
  };

  localparam logic [3:0] SBOX [8][64] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
  };

  function automatic logic [63:0] ip_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = v[64-int'(IP_TAB[k])];
    return r;
  endfunction

  function automatic logic [63:0] fp_perm(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) r[63-k] = v[64-int'(FP_TAB[k])];
    return r;
  endfunction

  function automatic logic [47:0] e_perm(input logic [31:0] v);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[47-k] = v[32-int'(E_TAB[k])];
    return r;
  endfunction

  function automatic logic [31:0] p_perm(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) r[31-k] = v[32-int'(P_TAB[k])];
    return r;
  endfunction

  function automatic logic [55:0] pc1_perm(input logic [63:0] v);
    logic [55:0] r;
    for (int k = 0; k < 56; k++) r[55-k] = v[64-int'(PC1_TAB[k])];
    return r;
  endfunction

  function automatic logic [47:0] pc2_perm(input logic [55:0] v);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) r[47-k] = v[56-int'(PC2_TAB[k])];
    return r;
  endfunction

  // Left rotation of a 28-bit key half; the amount is a constant per round.
  function automatic logic [27:0] rot28(input logic [27:0] v, input int unsigned s);
    logic [55:0] t;
    t = {v, v};
    return t[55-s -: 28];
  endfunction

  function automatic logic [47:0] round_subkey(input logic [63:0] key, input int unsigned rnd);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    cd = pc1_perm(key);
    c  = rot28(cd[55:28], ROT_SUM[rnd]);
    d  = rot28(cd[27:0], ROT_SUM[rnd]);
    return pc2_perm({c, d});
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] half, input logic [47:0] subkey);
    logic [47:0] x;
    logic [5:0]  six;
    logic [31:0] s;
    x = e_perm(half) ^ subkey;
    s = '0;
    for (int j = 0; j < 8; j++) begin
      six = x[47-6*j -: 6];
      s[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
    end
    return p_perm(s);
  endfunction

endpackage

// File: rtl/core/des_intf.sv
// Plaintext channel.
interface des_plain_if;
  logic                         valid;
  logic                         ready;
  logic [des_pkg::BLOCK_W-1:0]  plaintext_block;

  modport source (output valid, output plaintext_block, input ready);
  modport sink (input valid, input plaintext_block, output ready);
endinterface

// Ciphertext channel.
interface des_cipher_if;
  logic                         valid;
  logic                         ready;
  logic [des_pkg::BLOCK_W-1:0]  ciphertext_block;

  modport source (output valid, output ciphertext_block, input ready);
  modport sink (input valid, input ciphertext_block, output ready);
endinterface

// Key register write channel.
interface des_key_if;
  logic                         valid;
  logic                         ready;
  logic [des_pkg::KEY_W-1:0]    cipher_key;

  modport source (output valid, output cipher_key, input ready);
  modport sink (input valid, input cipher_key, output ready);
endinterface

// File: rtl/core/des_block_encrypt.sv
// DES encryption of single 64-bit blocks under a key held in a register.
//
// Channels: key_i writes the 64-bit key (parity bits are ignored) and is
// always ready; a write is meant to happen only while no block is in flight.
// plain_i takes one plaintext block per beat, cipher_o gives one ciphertext
// block per beat, in the same order. Bit 63 of each block is DES bit 1.
//
// Structure: sixteen round stages, one Feistel round each, followed by an
// output register that also applies the final permutation. The initial
// permutation is wiring in front of the first round. Subkeys are wiring
// from the key register, so every stage has the same depth: expansion,
// XOR, S-box lookup, P and XOR.
//
// Timing: an accepted plaintext passes through the sixteen round stages and
// then the output register. Throughput is one block per cycle while cipher_o is ready.
//
// Reset clears the key to zero and empties every stage. When the receiver
// stalls, the output register holds its beat and blocks behind it close up
// into empty stages; plain_i drops ready only once all 17 slots are full.
module des_block_encrypt (
  input  logic          clk_i,
  input  logic          rst_ni,
  des_key_if.sink       key_i,
  des_plain_if.sink     plain_i,
  des_cipher_if.source  cipher_o
);
  import des_pkg::*;

  localparam int unsigned NSTG = NUM_ROUNDS;

  logic [KEY_W-1:0]    key_q;
  logic [SUBKEY_W-1:0] subkey [NSTG];

  logic [HALF_W-1:0]   l_q [NSTG];
  logic [HALF_W-1:0]   r_q [NSTG];
  logic [HALF_W-1:0]   l_d [NSTG];
  logic [HALF_W-1:0]   r_d [NSTG];
  logic [NSTG-1:0]     v_q;
  logic [NSTG-1:0]     v_d;
  logic [NSTG-1:0]     en;
  logic [NSTG-1:0]     v_in;

  logic [BLOCK_W-1:0]  ip_blk;
  logic                out_en;
  logic                out_v_q;
  logic                out_v_d;
  logic [BLOCK_W-1:0]  ct_q;

  // Key register; the write channel never pushes back.
  assign key_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_i.valid) begin
      key_q <= key_i.cipher_key;
    end
  end

  // A stage loads when it is empty or when its content moves on in the same cycle.
  assign out_en = !out_v_q || cipher_o.ready;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_en;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign plain_i.ready = en[0];
  assign ip_blk        = ip_perm(plain_i.plaintext_block);

  for (genvar g = 0; g < NSTG; g++) begin : g_round
    assign subkey[g] = round_subkey(key_q, g);

    if (g == 0) begin : g_first
      assign v_in[g] = plain_i.valid;
      assign l_d[g]  = ip_blk[31:0];
      assign r_d[g]  = ip_blk[63:32] ^ feistel(ip_blk[31:0], subkey[g]);
    end else begin : g_next
      assign v_in[g] = v_q[g-1];
      assign l_d[g]  = r_q[g-1];
      assign r_d[g]  = l_q[g-1] ^ feistel(r_q[g-1], subkey[g]);
    end

    assign v_d[g] = en[g] ? v_in[g] : v_q[g];

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        l_q[g] <= l_d[g];
        r_q[g] <= r_d[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Output register: swap the halves and apply the final permutation.
  assign out_v_d = out_en ? v_q[NSTG-1] : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      ct_q <= fp_perm({r_q[NSTG-1], l_q[NSTG-1]});
    end
  end

  assign cipher_o.valid            = out_v_q;
  assign cipher_o.ciphertext_block = ct_q;

  // An accepted beat always lands in the first round stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plain_i.valid && plain_i.ready |=> v_q[0])
    else $error("accepted block did not enter the first round stage");

  // The last round stage hands its block to the output register when that is free.
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTG-1] && out_en |=> out_v_q)
    else $error("finished block was lost before the output register");

  // With every slot full and the receiver stalled, no new block is taken.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && out_v_q && !cipher_o.ready |-> !plain_i.ready)
    else $error("input ready while the pipeline is full and stalled");

  // A block in the last stage that cannot leave stays there.
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTG-1] && !out_en |=> v_q[NSTG-1])
    else $error("stalled block left the last round stage");

endmodule
